// File: hdl/cvd_pkg.sv
// Package for the CompactSize varint decoder: field widths, prefix codes,
// shortest-form bounds, encoded lengths and the configuration register map.
// No dependencies; every other file of the decoder refers to it by scoped names.
`timescale 1ns / 1ps
`default_nettype none

package cvd_pkg;

    // Widths of the item fields.
    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned VALUE_W = 64;
    localparam int unsigned LEN_W   = 4;
    localparam int unsigned LEFT_W  = 4;
    localparam int unsigned POS_W   = 3;

    // Configuration port: one 64-bit register at byte address 8*i.
    localparam int unsigned CFG_DATA_W = 64;
    localparam int unsigned CFG_ADDR_W = 4;
    localparam int unsigned CFG_IDX_LSB = 3;

    // Register indexes.
    typedef enum logic [CFG_ADDR_W-CFG_IDX_LSB-1:0] {
        REG_MAX_VALUE = 1'b0
    } t_reg_idx;

    localparam logic [VALUE_W-1:0] MAX_VALUE_RESET = 64'h0000_0000_0200_0000;

    // Prefix codes; any byte above PFX_U32 announces the 64-bit form.
    localparam logic [BYTE_W-1:0] PFX_U16 = 8'd253;
    localparam logic [BYTE_W-1:0] PFX_U32 = 8'd254;

    // Payload byte counts for each prefix.
    localparam logic [LEFT_W-1:0] PAYLOAD_U16 = 4'd2;
    localparam logic [LEFT_W-1:0] PAYLOAD_U32 = 4'd4;
    localparam logic [LEFT_W-1:0] PAYLOAD_U64 = 4'd8;

    // Total encoded lengths including the prefix.
    localparam logic [LEN_W-1:0] LEN_SINGLE = 4'd1;
    localparam logic [LEN_W-1:0] LEN_U16    = 4'd3;
    localparam logic [LEN_W-1:0] LEN_U32    = 4'd5;
    localparam logic [LEN_W-1:0] LEN_U64    = 4'd9;

    // Smallest value that is in shortest form for the 16-bit prefix.
    localparam logic [VALUE_W-1:0] MIN_U16_FORM = 64'd253;

endpackage : cvd_pkg

`default_nettype wire

// File: hdl/cvd_byte_if.sv
// Input channel of the varint decoder: one stream byte per item.
// Depends on cvd_pkg for the byte width.
`timescale 1ns / 1ps
`default_nettype none

interface cvd_byte_if;
    logic                          valid;
    logic                          ready;
    logic [cvd_pkg::BYTE_W-1:0]    data_byte;

    modport source (output valid, output data_byte, input ready);
    modport sink   (input valid, input data_byte, output ready);
endinterface : cvd_byte_if

`default_nettype wire

// File: hdl/cvd_result_if.sv
// Output channel of the varint decoder: one decoded varint per item.
// Depends on cvd_pkg for the field widths.
`timescale 1ns / 1ps
`default_nettype none

interface cvd_result_if;
    logic                          valid;
    logic                          ready;
    logic [cvd_pkg::VALUE_W-1:0]   value;
    logic                          ok;
    logic [cvd_pkg::LEN_W-1:0]     encoded_length;

    modport source (output valid, output value, output ok, output encoded_length,
                    input ready);
    modport sink   (input valid, input value, input ok, input encoded_length,
                    output ready);
endinterface : cvd_result_if

`default_nettype wire

// File: hdl/cvd_cfg_regs.sv
// APB-style configuration register file of the varint decoder (max_value).
// Depends on cvd_pkg for the register map and reset value.
`timescale 1ns / 1ps
`default_nettype none

module cvd_cfg_regs (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [cvd_pkg::CFG_ADDR_W-1:0]    paddr,
    input  wire logic [cvd_pkg::CFG_DATA_W-1:0]    pwdata,
    output logic      [cvd_pkg::CFG_DATA_W-1:0]    prdata,
    output logic                                   pready,
    output logic      [cvd_pkg::VALUE_W-1:0]       o_max_value
);

    logic [cvd_pkg::VALUE_W-1:0] r_max_value;
    logic                        w_sel_max;
    logic                        w_write;

    // Address decode: the byte offset within a register is ignored.
    assign w_sel_max = (cvd_pkg::t_reg_idx'(paddr[cvd_pkg::CFG_ADDR_W-1:cvd_pkg::CFG_IDX_LSB])
                        == cvd_pkg::REG_MAX_VALUE);
    assign w_write   = psel && penable && pwrite;

    // The port never inserts wait states.
    assign pready = 1'b1;

    // Register write in the access phase.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_value <= cvd_pkg::MAX_VALUE_RESET;
        end else if (w_write && w_sel_max) begin
            r_max_value <= pwdata;
        end
    end

    // Read-back; unmapped addresses read as zero.
    always_comb begin
        prdata = '0;
        if (w_sel_max) begin
            prdata = r_max_value;
        end
    end

    assign o_max_value = r_max_value;

endmodule : cvd_cfg_regs

`default_nettype wire

// File: hdl/compactsize_varint_decoder_core.sv
// CompactSize varint decoder, top level: byte parser, output register and config port.
// Depends on cvd_pkg, cvd_byte_if, cvd_result_if and cvd_cfg_regs.
//
// The decoder takes one stream byte per clock and delivers each decoded varint in the
// cycle after its last byte is accepted: value, ok flag and encoded length (1, 3, 5 or
// 9 bytes). A non-shortest encoding or a value above max_value gives ok low with value
// all ones. Throughput is one byte per cycle; the only stall is a held result in the
// single output register that the sink has not taken, and that register is freed in the
// same cycle it is read, so a ready sink never slows the stream. After any result the
// next byte is a new prefix. max_value is written over the APB port at address 0; the user
// must write it only while the stream is idle, as the block itself does not enforce this.
`timescale 1ns / 1ps
`default_nettype none

module compactsize_varint_decoder_core (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    cvd_byte_if.sink                               i_in,
    cvd_result_if.source                           o_out,
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [cvd_pkg::CFG_ADDR_W-1:0]    paddr,
    input  wire logic [cvd_pkg::CFG_DATA_W-1:0]    pwdata,
    output logic      [cvd_pkg::CFG_DATA_W-1:0]    prdata,
    output logic                                   pready
);

    // Parser state.
    logic [cvd_pkg::BYTE_W-1:0]  r_prefix,     n_prefix;
    logic [cvd_pkg::LEFT_W-1:0]  r_bytes_left, n_bytes_left;
    logic [cvd_pkg::VALUE_W-1:0] r_acc,        n_acc;
    logic [cvd_pkg::POS_W-1:0]   r_pos,        n_pos;

    // Output register.
    logic                        r_out_valid,  n_out_valid;
    logic [cvd_pkg::VALUE_W-1:0] r_value,      n_value;
    logic                        r_ok,         n_ok;
    logic [cvd_pkg::LEN_W-1:0]   r_len,        n_len;

    logic [cvd_pkg::VALUE_W-1:0] w_max_value;
    logic                        w_accept;
    logic [cvd_pkg::BYTE_W-1:0]  w_byte;
    logic [cvd_pkg::VALUE_W-1:0] w_acc_merged;
    logic [cvd_pkg::LEFT_W-1:0]  w_left_dec;
    logic                        w_emit;
    logic [cvd_pkg::VALUE_W-1:0] w_emit_value;
    logic                        w_canonical;
    logic [cvd_pkg::LEN_W-1:0]   w_emit_len;
    logic                        w_good;

    // Configuration register.
    cvd_cfg_regs u_cfg_regs (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .o_max_value (w_max_value)
    );

    // Accept a byte whenever the output register is empty or being drained.
    assign i_in.ready = !r_out_valid || o_out.ready;
    assign w_accept   = i_in.valid && i_in.ready;
    assign w_byte     = i_in.data_byte;

    // Payload byte merged into the accumulator at its little-endian position.
    assign w_acc_merged = r_acc | ({{(cvd_pkg::VALUE_W-cvd_pkg::BYTE_W){1'b0}}, w_byte}
                                   << {r_pos, 3'b000});
    assign w_left_dec   = r_bytes_left - 4'd1;

    // Parser: next state and the varint to emit, if any.
    always_comb begin
        n_prefix     = r_prefix;
        n_bytes_left = r_bytes_left;
        n_acc        = r_acc;
        n_pos        = r_pos;
        w_emit       = 1'b0;
        w_emit_value = w_acc_merged;
        w_canonical  = 1'b1;
        w_emit_len   = cvd_pkg::LEN_SINGLE;
        if (r_bytes_left == '0) begin
            if (w_byte < cvd_pkg::PFX_U16) begin
                // Single-byte varint.
                w_emit       = 1'b1;
                w_emit_value = {{(cvd_pkg::VALUE_W-cvd_pkg::BYTE_W){1'b0}}, w_byte};
            end else begin
                n_prefix = w_byte;
                n_acc    = '0;
                n_pos    = '0;
                unique case (w_byte)
                    cvd_pkg::PFX_U16: n_bytes_left = cvd_pkg::PAYLOAD_U16;
                    cvd_pkg::PFX_U32: n_bytes_left = cvd_pkg::PAYLOAD_U32;
                    default:          n_bytes_left = cvd_pkg::PAYLOAD_U64;
                endcase
            end
        end else begin
            n_acc        = w_acc_merged;
            n_pos        = r_pos + 3'd1;
            n_bytes_left = w_left_dec;
            if (w_left_dec == '0) begin
                // Last payload byte: check for shortest form.
                w_emit = 1'b1;
                n_acc  = '0;
                n_pos  = '0;
                unique case (r_prefix)
                    cvd_pkg::PFX_U16: begin
                        w_canonical = (w_acc_merged >= cvd_pkg::MIN_U16_FORM);
                        w_emit_len  = cvd_pkg::LEN_U16;
                    end
                    cvd_pkg::PFX_U32: begin
                        w_canonical = (w_acc_merged[cvd_pkg::VALUE_W-1:16] != '0);
                        w_emit_len  = cvd_pkg::LEN_U32;
                    end
                    default: begin
                        w_canonical = (w_acc_merged[cvd_pkg::VALUE_W-1:32] != '0);
                        w_emit_len  = cvd_pkg::LEN_U64;
                    end
                endcase
            end
        end
    end

    // Limit check and the result register's next contents.
    assign w_good = w_canonical && (w_emit_value <= w_max_value);

    always_comb begin
        n_out_valid = r_out_valid && !o_out.ready;
        n_value     = r_value;
        n_ok        = r_ok;
        n_len       = r_len;
        if (w_accept && w_emit) begin
            n_out_valid = 1'b1;
            n_value     = w_good ? w_emit_value : '1;
            n_ok        = w_good;
            n_len       = w_emit_len;
        end
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bytes_left <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
            if (w_accept) begin
                r_bytes_left <= n_bytes_left;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_prefix <= n_prefix;
            r_acc    <= n_acc;
            r_pos    <= n_pos;
        end
        r_value <= n_value;
        r_ok    <= n_ok;
        r_len   <= n_len;
    end

    assign o_out.valid          = r_out_valid;
    assign o_out.value          = r_value;
    assign o_out.ok             = r_ok;
    assign o_out.encoded_length = r_len;

endmodule : compactsize_varint_decoder_core

`default_nettype wire

// File: tb/tb_compactsize_varint_decoder_core.sv
// Self-checking testbench for the CompactSize varint decoder core.
// Depends on cvd_pkg, cvd_byte_if, cvd_result_if and the decoder RTL.
// A scoreboard predicts every decoded varint and checks the result items.
`timescale 1ns / 1ps

import cvd_pkg::*;

// Shortest-form bounds for the wider prefixes, and the 64-bit prefix code.
localparam logic [VALUE_W-1:0] MIN_U32_FORM = 64'h0000_0000_0001_0000;
localparam logic [VALUE_W-1:0] MIN_U64_FORM = 64'h0000_0001_0000_0000;
localparam logic [BYTE_W-1:0]  PFX_U64      = 8'hFF;

typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic               ok;
    logic [LEN_W-1:0]   encoded_length;
} t_varint_result;

// Tracks the decoder state from the accepted bytes and holds the varints still due.
class varint_scoreboard;
    logic [VALUE_W-1:0] limit = MAX_VALUE_RESET;
    logic [BYTE_W-1:0]  prefix = '0;
    logic [LEFT_W-1:0]  left = '0;
    logic [VALUE_W-1:0] acc = '0;
    logic [POS_W-1:0]   pos = '0;
    t_varint_result     due_varints[$];
    int unsigned        errors = 0;
    int unsigned        checked = 0;
    int unsigned        accepted = 0;
    int unsigned        flagged = 0;
    int unsigned        bytes_seen = 0;

    task report(input string msg);
        errors++;
        $display("mismatch at %0t: %s", $realtime, msg);
    endtask

    function int pending();
        return due_varints.size();
    endfunction

    function void queue_result(input logic [VALUE_W-1:0] v, input logic canonical,
                               input logic [LEN_W-1:0] len);
        t_varint_result r;
        logic good;
        good = canonical && (v <= limit);
        r.value = good ? v : '1;
        r.ok = good;
        r.encoded_length = len;
        due_varints.push_back(r);
    endfunction

    // Advances the decoder state by one accepted byte.
    function void note_byte(input logic [BYTE_W-1:0] b);
        bytes_seen++;
        if (left == '0) begin
            if (b < PFX_U16) begin
                queue_result(VALUE_W'(b), 1'b1, LEN_SINGLE);
            end else begin
                prefix = b;
                acc = '0;
                pos = '0;
                if (b == PFX_U16) begin
                    left = PAYLOAD_U16;
                end else if (b == PFX_U32) begin
                    left = PAYLOAD_U32;
                end else begin
                    left = PAYLOAD_U64;
                end
            end
        end else begin
            acc |= VALUE_W'(b) << (8 * pos);
            pos = pos + 1'b1;
            left = left - 1'b1;
            if (left == '0) begin
                if (prefix == PFX_U16) begin
                    queue_result(acc, acc >= MIN_U16_FORM, LEN_U16);
                end else if (prefix == PFX_U32) begin
                    queue_result(acc, acc >= MIN_U32_FORM, LEN_U32);
                end else begin
                    queue_result(acc, acc >= MIN_U64_FORM, LEN_U64);
                end
                acc = '0;
                pos = '0;
            end
        end
    endfunction

    // Compares one result item with the oldest varint still due.
    task check_result(input logic [VALUE_W-1:0] value, input logic ok,
                      input logic [LEN_W-1:0] len);
        t_varint_result want;
        if (due_varints.size() == 0) begin
            report($sformatf("unexpected result value=%h ok=%b len=%0d", value, ok, len));
            return;
        end
        want = due_varints.pop_front();
        checked++;
        if (want.ok) begin
            accepted++;
        end else begin
            flagged++;
        end
        if (value !== want.value || ok !== want.ok || len !== want.encoded_length) begin
            report($sformatf("varint %0d: got value=%h ok=%b len=%0d, want value=%h ok=%b len=%0d",
                             checked, value, ok, len, want.value, want.ok, want.encoded_length));
        end
    endtask
endclass

module tb_compactsize_varint_decoder_core;

    localparam int unsigned CLK_PERIOD    = 8;
    localparam int unsigned RESET_CYCLES  = 9;
    localparam int unsigned SETTLE_CYCLES = 4;
    localparam int unsigned HOLD_CYCLES   = 150;
    localparam int unsigned PHASE_BYTES   = 170;

    // Register addresses; the second index is not mapped to any register.
    localparam logic [CFG_ADDR_W-CFG_IDX_LSB-1:0] IDX_UNMAPPED = 1'b1;
    localparam logic [CFG_ADDR_W-1:0] ADDR_MAX_VALUE = {REG_MAX_VALUE, {CFG_IDX_LSB{1'b0}}};
    localparam logic [CFG_ADDR_W-1:0] ADDR_UNMAPPED  = {IDX_UNMAPPED, {CFG_IDX_LSB{1'b0}}};

    localparam logic [VALUE_W-1:0] BOUNDARY_VALUES [8] = '{
        64'd0, 64'd252, 64'd253, 64'h0000_0000_0000_FFFF, 64'h0000_0000_0001_0000,
        64'h0000_0000_FFFF_FFFF, 64'h0000_0001_0000_0000, 64'hFFFF_FFFF_FFFF_FFFF
    };

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [CFG_ADDR_W-1:0] paddr;
    logic [CFG_DATA_W-1:0] pwdata;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;

    cvd_byte_if   byte_if ();
    cvd_result_if res_if ();

    varint_scoreboard sb = new();

    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;
    int unsigned hold_left = 0;
    int unsigned settings_written = 0;

    compactsize_varint_decoder_core uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (byte_if),
        .o_out   (res_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Free-running clock.
    initial begin
        i_clk = 1'b0;
        forever #(CLK_PERIOD / 2) i_clk = ~i_clk;
    end

    // Result receiver: random stalls, or a long hold-off counted down here.
    initial begin
        res_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_left != 0) begin
                res_if.ready = 1'b0;
                hold_left--;
            end else begin
                res_if.ready = ($urandom_range(0, 99) >= recv_idle_pct);
            end
        end
    end

    // Accepted bytes are noted before results are checked, so a result in the
    // same cycle as its last byte would still find its prediction.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (byte_if.valid && byte_if.ready) begin
                sb.note_byte(byte_if.data_byte);
            end
            if (res_if.valid && res_if.ready) begin
                sb.check_result(res_if.value, res_if.ok, res_if.encoded_length);
            end
        end
    end

    // Hard limit on the run time.
    initial begin
        #2_000_000;
        $display("FAIL compactsize_varint_decoder_core");
        $finish;
    end

    // Waits until every predicted varint has arrived, then lets the block settle.
    task automatic wait_idle();
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // APB write followed by a read-back of max_value.
    task automatic cfg_write(input logic [CFG_ADDR_W-1:0] addr,
                             input logic [CFG_DATA_W-1:0] data);
        psel = 1'b1;
        penable = 1'b0;
        pwrite = 1'b1;
        paddr = addr;
        pwdata = data;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        if (addr == ADDR_MAX_VALUE) begin
            sb.limit = data;
            settings_written++;
        end
        @(negedge i_clk);
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = ADDR_MAX_VALUE;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata !== sb.limit) begin
            sb.report($sformatf("max_value reads %h, expected %h", prdata, sb.limit));
        end
        @(negedge i_clk);
        psel = 1'b0;
        penable = 1'b0;
    endtask

    // Offers each byte in turn; valid stays high between bytes unless the sender idles or pauses.
    task automatic send_stream(input logic [BYTE_W-1:0] stream[$], input int hold_at,
                               input int pause_at);
        for (int i = 0; i < stream.size(); i++) begin
            if (i == hold_at) begin
                hold_left = HOLD_CYCLES;
            end
            if (i == pause_at) begin
                byte_if.valid = 1'b0;
                wait_idle();
            end
            while ($urandom_range(0, 99) < send_idle_pct) begin
                byte_if.valid = 1'b0;
                @(negedge i_clk);
            end
            byte_if.valid = 1'b1;
            byte_if.data_byte = stream[i];
            do @(posedge i_clk); while (!byte_if.ready);
            @(negedge i_clk);
        end
        byte_if.valid = 1'b0;
    endtask

    // Builds a stream of whole varints with random values and values near the interesting bounds,
    // some of them in a longer form than needed, and sends it.
    task automatic run_random_phase(input int unsigned send_idle, input int unsigned recv_idle,
                                    input bit with_hold, input bit with_pause);
        logic [BYTE_W-1:0]  stream[$];
        logic [VALUE_W-1:0] v;
        logic [LEN_W-1:0]   form;
        logic [LEN_W-1:0]   longer;
        send_idle_pct = send_idle;
        recv_idle_pct = recv_idle;
        while (stream.size() < PHASE_BYTES) begin
            case ($urandom_range(0, 7))
                0, 1: v = VALUE_W'($urandom_range(0, 252));
                2: v = {$urandom, $urandom} >> $urandom_range(0, VALUE_W - 1);
                3: v = BOUNDARY_VALUES[$urandom_range(0, 7)];
                4: v = sb.limit + VALUE_W'($urandom_range(0, 2)) - 1'b1;
                default: v = VALUE_W'($urandom) >> $urandom_range(0, 31);
            endcase
            if (v < MIN_U16_FORM) begin
                form = LEN_SINGLE;
            end else if (v < MIN_U32_FORM) begin
                form = LEN_U16;
            end else if (v < MIN_U64_FORM) begin
                form = LEN_U32;
            end else begin
                form = LEN_U64;
            end
            // About one varint in five draws a form to pad to; it is padded only if that form is wider.
            if ($urandom_range(0, 4) == 0) begin
                case ($urandom_range(0, 2))
                    0: longer = LEN_U16;
                    1: longer = LEN_U32;
                    default: longer = LEN_U64;
                endcase
                if (longer > form) begin
                    form = longer;
                end
            end
            case (form)
                LEN_SINGLE: stream.push_back(v[BYTE_W-1:0]);
                LEN_U16: stream.push_back(PFX_U16);
                LEN_U32: stream.push_back(PFX_U32);
                default: stream.push_back(PFX_U64);
            endcase
            for (int k = 1; k < form; k++) begin
                stream.push_back(v[8*(k-1) +: 8]);
            end
        end
        send_stream(stream, with_hold ? int'(PHASE_BYTES / 3) : -1,
                    with_pause ? int'(PHASE_BYTES / 2) : -1);
        wait_idle();
    endtask

    // Main sequence: reset, directed cases, then random phases under several limits.
    initial begin
        logic [BYTE_W-1:0] directed[$];
        i_rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        byte_if.valid = 1'b0;
        byte_if.data_byte = '0;
        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // A write to the unmapped index must leave the reset limit in place.
        cfg_write(ADDR_UNMAPPED, '0);

        // Single bytes, padded 16-bit form, shortest 16-bit, padded 32-bit and
        // a 32-bit value just above the reset limit.
        directed = {8'h00, 8'hFC, PFX_U16, 8'hFC, 8'h00, PFX_U16, 8'hFD, 8'h00,
                    PFX_U32, 8'hFF, 8'hFF, 8'h00, 8'h00, PFX_U32, 8'h01, 8'h00, 8'h00, 8'h02};
        send_stream(directed, -1, -1);
        wait_idle();

        // Zero limit: only a zero value passes.
        cfg_write(ADDR_MAX_VALUE, '0);
        directed = {8'h00, 8'h01};
        send_stream(directed, -1, -1);
        wait_idle();

        // Full limit: the all-ones value must pass with ok set.
        cfg_write(ADDR_MAX_VALUE, '1);
        directed = {PFX_U64, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF};
        send_stream(directed, -1, -1);
        wait_idle();

        cfg_write(ADDR_MAX_VALUE, {$urandom, $urandom} >> $urandom_range(0, VALUE_W - 1));
        run_random_phase(32, 74, 1'b0, 1'b0);
        cfg_write(ADDR_MAX_VALUE, '1);
        run_random_phase(74, 32, 1'b0, 1'b0);
        cfg_write(ADDR_MAX_VALUE, MAX_VALUE_RESET);
        run_random_phase(0, 0, 1'b1, 1'b0);
        cfg_write(ADDR_MAX_VALUE, VALUE_W'($urandom));
        run_random_phase(0, 0, 1'b0, 1'b1);

        $display("Covered %0d stream bytes and %0d varints (%0d within limit, %0d flagged),",
                 sb.bytes_seen, sb.checked, sb.accepted, sb.flagged);
        $display("under %0d max_value settings with idling, stalls and a long hold-off.",
                 settings_written);
        if (sb.errors == 0) begin
            $display("PASS compactsize_varint_decoder_core");
        end else begin
            $display("FAIL compactsize_varint_decoder_core");
        end
        $finish;
    end

endmodule

// File: sim.f
hdl/cvd_pkg.sv
hdl/cvd_byte_if.sv
hdl/cvd_result_if.sv
hdl/cvd_cfg_regs.sv
hdl/compactsize_varint_decoder_core.sv
tb/tb_compactsize_varint_decoder_core.sv
